FILE: hdl/rse_pkg.sv
// shared constants, codes and helpers for the rpn stack evaluator
// no dependencies; imported by rse_alu, rpn_stack_evaluator, rse_checker and tb
package rse_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int DATA_W      = 32;
  localparam int SYM_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 7;
  localparam int MIN_OPERANDS = 2;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W = ((DATA_W + SYM_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + DEPTH_W + 7) / 8) * 8;

  // token kinds
  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_SYMBOL = 1'b1;

  // symbol codes
  typedef enum logic [SYM_W-1:0] {
    SYM_ADD   = 2'd0,
    SYM_SUB   = 2'd1,
    SYM_MUL   = 2'd2,
    SYM_OTHER = 2'd3
  } sym_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_HALTED    = 3'd4
  } status_t;

  // entry count reported on the fixed-width depth field
  function automatic logic [DEPTH_W-1:0] to_depth(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+DEPTH_W-1:0] wide;
    wide = {{DEPTH_W{1'b0}}, cnt};
    return wide[DEPTH_W-1:0];
  endfunction

endpackage

FILE: hdl/rse_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module rse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rse_alu.sv
// two-operand integer unit: add, subtract, multiply, all wrapping to 32 bits
// depends on rse_pkg
module rse_alu import rse_pkg::*; (
  input  sym_t              op,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] res
);

  logic [DATA_W-1:0] prod;

  // low half of the product is all that is kept
  assign prod = a * b;

  always_comb begin
    case (op)
      SYM_ADD: res = a + b;
      SYM_SUB: res = a - b;
      SYM_MUL: res = prod;
      default: res = prod;
    endcase
  end

endmodule

FILE: hdl/rpn_stack_evaluator.sv
// rpn stack evaluator: one token per beat on a 32-bit operand stack
// timing: push, error and ignored tokens give their result in the cycle after the beat;
//   an operator gives its result from S_EXEC, once the second operand is read from the ram
// throughput: one push per cycle unless the output stalls; no token is taken in S_EXEC (ram read)
// reset clears the entry count, the halt flag and the output valid flag;
//   stack ram contents are left as they are, no clearing pass
module rpn_stack_evaluator import rse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // value[31:0], symbol_code[33:32], zero pad
  input  logic                 s_axis_tuser,  // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // top_value[31:0], depth[38:32], zero pad
  output logic [STATUS_W-1:0]  m_axis_tuser   // status[2:0]
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              halted;
  logic [DATA_W-1:0] top_reg;
  sym_t              op_reg;

  logic              out_valid;
  status_t           out_status;
  logic [DATA_W-1:0] out_top;
  logic [DEPTH_W-1:0] out_depth;

  logic              accept;
  logic              cmd_in;
  logic [DATA_W-1:0] value_in;
  sym_t              sym_in;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  cnt_m2;
  logic [CNT_W-1:0]  cnt_p1;
  logic [DATA_W-1:0] cur_top;
  logic              full;
  logic              ram_we;
  logic [DATA_W-1:0] second;
  logic [DATA_W-1:0] alu_res;

  // input beat fields
  assign cmd_in   = s_axis_tuser;
  assign value_in = s_axis_tdata[DATA_W-1:0];
  assign sym_in   = sym_t'(s_axis_tdata[DATA_W+SYM_W-1:DATA_W]);

  // take a beat only when idle and the output slot is free or draining
  assign s_axis_tready = (state == S_IDLE) && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cnt_m1  = count - CNT_W'(1);
  assign cnt_m2  = count - CNT_W'(2);
  assign cnt_p1  = count + CNT_W'(1);
  assign full    = (count == CNT_W'(STACK_DEPTH));
  assign cur_top = (count == '0) ? '0 : top_reg;

  // a push spills the cached top into the ram below the new top
  assign ram_we = accept && !halted && (cmd_in == CMD_PUSH) && !full && (count != '0);

  rse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[ADDR_W-1:0]),
    .wdata (top_reg),
    .raddr (cnt_m2[ADDR_W-1:0]),
    .rdata (second)
  );

  rse_alu u_alu (
    .op  (op_reg),
    .a   (second),
    .b   (top_reg),
    .res (alu_res)
  );

  // token sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      halted    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (halted) begin
              out_valid  <= 1'b1;
              out_status <= ST_HALTED;
              out_top    <= cur_top;
              out_depth  <= to_depth(count);
            end else if (cmd_in == CMD_PUSH) begin
              out_valid <= 1'b1;
              if (full) begin
                out_status <= ST_OVERFLOW;
                halted     <= 1'b1;
                out_top    <= cur_top;
                out_depth  <= to_depth(count);
              end else begin
                out_status <= ST_OK;
                top_reg    <= value_in;
                count      <= cnt_p1;
                out_top    <= value_in;
                out_depth  <= to_depth(cnt_p1);
              end
            end else if (sym_in == SYM_OTHER) begin
              out_valid  <= 1'b1;
              out_status <= ST_UNKNOWN;
              halted     <= 1'b1;
              out_top    <= cur_top;
              out_depth  <= to_depth(count);
            end else if (count < CNT_W'(MIN_OPERANDS)) begin
              out_valid  <= 1'b1;
              out_status <= ST_UNDERFLOW;
              halted     <= 1'b1;
              out_top    <= cur_top;
              out_depth  <= to_depth(count);
            end else begin
              // wait in S_EXEC for the second entry from the ram
              out_valid <= 1'b0;
              op_reg    <= sym_in;
              state     <= S_EXEC;
            end
          end else if (out_valid && m_axis_tready) begin
            out_valid <= 1'b0;
          end
        end
        S_EXEC: begin
          top_reg    <= alu_res;
          count      <= cnt_m1;
          out_valid  <= 1'b1;
          out_status <= ST_OK;
          out_top    <= alu_res;
          out_depth  <= to_depth(cnt_m1);
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output beat
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - DEPTH_W){1'b0}}, out_depth, out_top};

endmodule

FILE: test/rse_checker.sv
// result checker for the rpn stack evaluator: watches both stream channels,
// models the operand stack and compares every result beat; needs rse_pkg
`timescale 1ns / 1ps

module rse_checker import rse_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // value[31:0], symbol_code[33:32], zero pad
  input  logic                 s_axis_tuser,  // cmd
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,  // top_value[31:0], depth[38:32], zero pad
  input  logic [STATUS_W-1:0]  m_axis_tuser,  // status[2:0]
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   top;
    logic [DEPTH_W-1:0]  depth;
  } outcome_t;

  // modeled stack contents, entry count and halt flag
  logic [DATA_W-1:0] entries [STACK_DEPTH];
  int                held;
  logic              stopped;

  outcome_t expected_outcomes[$];

  // run one token on the modeled stack and return the result it gives
  function automatic outcome_t evaluate_token(input logic cmd, input logic [DATA_W-1:0] val,
                                              input sym_t sym);
    outcome_t          res;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
    res.status = ST_OK;
    if (stopped) begin
      res.status = ST_HALTED;
    end else if (cmd == CMD_PUSH) begin
      if (held >= STACK_DEPTH) begin
        res.status = ST_OVERFLOW;
        stopped = 1'b1;
      end else begin
        entries[held] = val;
        held++;
      end
    end else if (sym == SYM_OTHER) begin
      // symbol is resolved before the operand count is looked at
      res.status = ST_UNKNOWN;
      stopped = 1'b1;
    end else if (held < MIN_OPERANDS) begin
      res.status = ST_UNDERFLOW;
      stopped = 1'b1;
    end else begin
      rhs = entries[held-1];
      lhs = entries[held-2];
      held--;
      case (sym)
        SYM_ADD: entries[held-1] = lhs + rhs;
        SYM_SUB: entries[held-1] = lhs - rhs;
        default: entries[held-1] = lhs * rhs;
      endcase
    end
    res.top = (held == 0) ? '0 : entries[held-1];
    res.depth = DEPTH_W'(held);
    return res;
  endfunction

  // result side first so a beat never matches a token taken at the same edge
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      expected_outcomes.delete();
      held = 0;
      stopped = 1'b0;
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_t'(m_axis_tuser);
        got.top = m_axis_tdata[DATA_W-1:0];
        got.depth = m_axis_tdata[DATA_W +: DEPTH_W];
        if (expected_outcomes.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with nothing expected: status %0d top %h depth %0d",
                     $realtime, got.status, got.top, got.depth);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: mismatch status exp %0d got %0d, top exp %h got %h, depth exp %0d got %0d",
                       $realtime, want.status, got.status, want.top, got.top,
                       want.depth, got.depth);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_outcomes.push_back(evaluate_token(s_axis_tuser, s_axis_tdata[DATA_W-1:0],
                                                   sym_t'(s_axis_tdata[DATA_W +: SYM_W])));
    end
    pending = expected_outcomes.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    held = 0;
    stopped = 1'b0;
  end

endmodule

FILE: test/tb.sv
// testbench top for the rpn stack evaluator: drives token streams, paces the
// result side and gives the verdict; needs rse_pkg, rse_checker and the block
`timescale 1ns / 1ps

module tb import rse_pkg::*; ();

  localparam int RANDOM_TOKENS = 1800;
  localparam int QUIET_TAIL    = 150;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 500;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  int   fail_count;
  int   pending;
  int   tokens_sent;
  int   stack_level;
  int   gap_pct;
  int   idle_cycles;
  logic quiet;
  logic done;

  rpn_stack_evaluator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  rse_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // operand values weighted toward the wraparound corners
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5, 6: return DATA_W'($urandom_range(0, 511)) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  // offer one token beat and wait until it is taken
  task automatic send_token(input logic cmd, input logic [DATA_W-1:0] val,
                            input logic [SYM_W-1:0] sym);
    if (tokens_sent % 100 == 0)
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = {{(S_TDATA_W-DATA_W-SYM_W){1'b0}}, sym, val};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tokens_sent++;
    if (cmd == CMD_PUSH)
      stack_level++;
    else
      stack_level--;
    @(negedge clk);
  endtask

  task automatic send_push(input logic [DATA_W-1:0] val);
    send_token(CMD_PUSH, val, SYM_W'($urandom));
  endtask

  task automatic send_op(input sym_t sym);
    send_token(CMD_SYMBOL, $urandom, sym);
  endtask

  // result side: random stall bursts, one long hold-off to back up the input
  initial begin
    int   seg_cycles;
    int   stall_pct;
    logic held_off;
    m_axis_tready = 1'b0;
    seg_cycles = 0;
    stall_pct = 0;
    held_off = 1'b0;
    forever begin
      @(negedge clk);
      if (seg_cycles % 256 == 0)
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 20;
        endcase
      seg_cycles++;
      if (!held_off && tokens_sent >= HOLD_AT) begin
        held_off = 1'b1;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || done || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic going_up;
    int   ending;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_PUSH;
    tokens_sent = 0;
    stack_level = 0;
    gap_pct = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    done = 1'b0;
    going_up = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: wraparound corners of each operator, stray symbol bits on pushes
    send_push(32'h7fff_ffff);
    send_push(32'h0000_0001);
    send_op(SYM_ADD);
    send_token(CMD_PUSH, 32'h8000_0000, SYM_OTHER);
    send_op(SYM_SUB);
    send_push(32'hffff_ffff);
    send_push(32'hffff_ffff);
    send_op(SYM_MUL);
    send_push(32'h8000_0000);
    send_push(32'hffff_ffff);
    send_op(SYM_MUL);
    send_push(32'h7fff_ffff);
    send_op(SYM_MUL);
    send_push(32'h0000_0000);
    send_op(SYM_SUB);
    send_token(CMD_PUSH, 32'h1234_5678, SYM_MUL);
    send_op(SYM_SUB);
    send_op(SYM_ADD);
    send_push(32'hffff_ffff);
    send_push(32'h8000_0000);
    send_op(SYM_SUB);
    send_op(SYM_ADD);

    // random walk over the stack depth, touching full and near-empty often
    for (int i = 0; i < RANDOM_TOKENS; i++) begin
      if (i >= RANDOM_TOKENS - QUIET_TAIL)
        quiet = 1'b1;
      if (stack_level >= STACK_DEPTH)
        going_up = 1'b0;
      else if (stack_level <= MIN_OPERANDS)
        going_up = 1'b1;
      else if ($urandom_range(0, 59) == 0)
        going_up = ~going_up;
      if (stack_level < MIN_OPERANDS)
        send_push(pick_value());
      else if (stack_level >= STACK_DEPTH)
        send_op(sym_t'($urandom_range(0, 2)));
      else if ($urandom_range(0, 99) < (going_up ? 75 : 25))
        send_push(pick_value());
      else
        send_op(sym_t'($urandom_range(0, 2)));
    end

    // one error halts for good, so each run ends on one error kind
    quiet = 1'b1;
    ending = $urandom_range(0, 2);
    case (ending)
      0: begin
        while (stack_level < STACK_DEPTH) send_push(pick_value());
        send_push(pick_value());
      end
      1: begin
        while (stack_level > 1) send_op(sym_t'($urandom_range(0, 2)));
        send_op(sym_t'($urandom_range(0, 2)));
      end
      default: send_op(SYM_OTHER);
    endcase

    // tokens after the halt are only reported, never executed
    repeat (20) send_token(1'($urandom), $urandom, SYM_W'($urandom));
    s_axis_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    done = 1'b1;
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
